>>> rtl/kct_pkg.sv
package kct_pkg;

    // internal word: signed q16.32 in 48 bits
    localparam int QW = 48;
    localparam logic signed [QW-1:0] QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] QMIN = 48'sh8000_0000_0000;
    localparam logic signed [QW-1:0] QONE = 48'sh0001_0000_0000;

    localparam logic [14:0] TICK_WRAP = 15'd30000;
    localparam logic [14:0] CNT_MAX   = 15'd32767;

    // configuration register indices
    localparam logic [2:0] CFG_TICK_PERIOD = 3'd0;
    localparam logic [2:0] CFG_Q_POS       = 3'd1;
    localparam logic [2:0] CFG_Q_CROSS     = 3'd2;
    localparam logic [2:0] CFG_Q_VEL       = 3'd3;
    localparam logic [2:0] CFG_R_XY        = 3'd4;
    localparam logic [2:0] CFG_R_Z         = 3'd5;

    // configuration reset values
    localparam logic [32:0] RST_TICK_PERIOD = 33'd214748365;
    localparam logic [40:0] RST_Q_POS       = 41'd671089;
    localparam logic [41:0] RST_Q_CROSS     = 42'd134217728;
    localparam logic [40:0] RST_Q_VEL       = 41'd26843545600;
    localparam logic [40:0] RST_R_XY        = 41'd1288490189;
    localparam logic [40:0] RST_R_Z         = 41'd1159641170;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_TICK,
        OP_DT,
        OP_OUT
    } t_op;

    // operand and destination selects; codes with bit 4 set are scratch registers
    typedef enum logic [4:0] {
        S_NONE  = 5'd0,
        S_EPOS  = 5'd1,
        S_EVEL  = 5'd2,
        S_P00   = 5'd3,
        S_P01   = 5'd4,
        S_P11   = 5'd5,
        S_PRPOS = 5'd6,
        S_PRVEL = 5'd7,
        S_Z     = 5'd8,
        S_R     = 5'd9,
        S_QP    = 5'd10,
        S_QC    = 5'd11,
        S_QV    = 5'd12,
        S_TP    = 5'd13,
        S_DT    = 5'd16,
        S_T1    = 5'd17,
        S_T2    = 5'd18,
        S_X0    = 5'd19,
        S_A     = 5'd20,
        S_P00N  = 5'd21,
        S_P01N  = 5'd22,
        S_P11N  = 5'd23,
        S_S     = 5'd24,
        S_K0    = 5'd25,
        S_K1    = 5'd26,
        S_INN   = 5'd27
    } t_sel;

    localparam int NTMP = 12;

    typedef struct packed {
        t_op  op;
        t_sel dst;
        t_sel a;
        t_sel b;
    } t_uop;

    typedef struct packed {
        logic       start;
        t_uop       uop;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_stat;

    // microprogram entry points
    localparam logic [4:0] PC_TICK     = 5'd0;
    localparam logic [4:0] PC_COPY     = 5'd1;
    localparam logic [4:0] PC_COPY_END = 5'd2;
    localparam logic [4:0] PC_DR       = 5'd3;
    localparam logic [4:0] PC_DR_END   = 5'd4;
    localparam logic [4:0] PC_OUT      = 5'd5;
    localparam logic [4:0] PC_DT       = 5'd6;
    localparam logic [4:0] PC_OBS      = 5'd7;
    localparam logic [4:0] PC_OBS_END  = 5'd31;

    function automatic t_uop uop_rom(input logic [4:0] pc);
        t_uop u;
        u = '{OP_NOP, S_NONE, S_NONE, S_NONE};
        case (pc)
            5'd0:  u = '{OP_TICK, S_NONE,  S_NONE,  S_NONE};
            5'd1:  u = '{OP_MOV,  S_PRPOS, S_EPOS,  S_NONE};
            5'd2:  u = '{OP_MOV,  S_PRVEL, S_EVEL,  S_NONE};
            5'd3:  u = '{OP_MUL,  S_T1,    S_TP,    S_PRVEL};
            5'd4:  u = '{OP_ADD,  S_PRPOS, S_PRPOS, S_T1};
            5'd5:  u = '{OP_OUT,  S_NONE,  S_NONE,  S_NONE};
            5'd6:  u = '{OP_DT,   S_DT,    S_NONE,  S_NONE};
            // predict
            5'd7:  u = '{OP_MUL,  S_T1,    S_DT,    S_EVEL};
            5'd8:  u = '{OP_ADD,  S_X0,    S_EPOS,  S_T1};
            5'd9:  u = '{OP_MUL,  S_T1,    S_DT,    S_P11};
            5'd10: u = '{OP_ADD,  S_A,     S_P01,   S_T1};
            5'd11: u = '{OP_MUL,  S_T1,    S_DT,    S_P01};
            5'd12: u = '{OP_ADD,  S_T2,    S_P00,   S_T1};
            5'd13: u = '{OP_MUL,  S_T1,    S_DT,    S_A};
            5'd14: u = '{OP_ADD,  S_T2,    S_T2,    S_T1};
            5'd15: u = '{OP_ADD,  S_P00N,  S_T2,    S_QP};
            5'd16: u = '{OP_ADD,  S_P01N,  S_A,     S_QC};
            5'd17: u = '{OP_ADD,  S_P11N,  S_P11,   S_QV};
            // gain
            5'd18: u = '{OP_ADD,  S_S,     S_P00N,  S_R};
            5'd19: u = '{OP_DIV,  S_K0,    S_P00N,  S_S};
            5'd20: u = '{OP_DIV,  S_K1,    S_P01N,  S_S};
            // update
            5'd21: u = '{OP_SUB,  S_INN,   S_Z,     S_X0};
            5'd22: u = '{OP_MUL,  S_T1,    S_K0,    S_INN};
            5'd23: u = '{OP_ADD,  S_EPOS,  S_X0,    S_T1};
            5'd24: u = '{OP_MUL,  S_T1,    S_K1,    S_INN};
            5'd25: u = '{OP_ADD,  S_EVEL,  S_EVEL,  S_T1};
            5'd26: u = '{OP_MUL,  S_T1,    S_K0,    S_P00N};
            5'd27: u = '{OP_SUB,  S_P00,   S_P00N,  S_T1};
            5'd28: u = '{OP_MUL,  S_T1,    S_K0,    S_P01N};
            5'd29: u = '{OP_SUB,  S_P01,   S_P01N,  S_T1};
            5'd30: u = '{OP_MUL,  S_T1,    S_K1,    S_P01N};
            5'd31: u = '{OP_SUB,  S_P11,   S_P11N,  S_T1};
            default: u = '{OP_NOP, S_NONE, S_NONE, S_NONE};
        endcase
        return u;
    endfunction

endpackage

>>> rtl/kct_in_if.sv
interface kct_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;

    modport source (output valid, output opcode, output meas_x, output meas_y,
                    output meas_z, input ready);
    modport sink (input valid, input opcode, input meas_x, input meas_y,
                  input meas_z, output ready);
endinterface

>>> rtl/kct_out_if.sv
interface kct_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

>>> rtl/kalman_cv_tracker_3d.sv
// constant-velocity kalman tracker for one point in 3-d, fixed point (q16.32 inside,
// q16.16 at the ports, saturating). one request is taken at a time. a tick request
// advances the tick counter, refreshes or dead-reckons the prediction and returns the
// predicted position as one result, waiting for the output register if it is full.
// an observation request runs predict and update on the three axes one after another
// and returns nothing; its run time is set by the 80-step restoring divider (two
// divisions per axis) and the single shared 24x24 multiplier that builds each 48-bit
// product from four partial products. configuration may be written only while idle.
module kalman_cv_tracker_3d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kct_in_if.sink      i_in,
    kct_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [41:0] i_cfg_data
);

    kct_pkg::t_cmd  cmd;
    kct_pkg::t_stat stat;
    logic           in_ready;

    // request handshake on the input side
    assign i_in.ready = in_ready;

    // controller: walks the microprogram, one datapath operation at a time
    kct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: state, configuration, multiplier, divider and output register
    kct_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_fire   (i_in.valid && in_ready),
        .i_meas_x    (i_in.meas_x),
        .i_meas_y    (i_in.meas_y),
        .i_meas_z    (i_in.meas_z),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_pos_x     (o_out.pos_x),
        .o_pos_y     (o_out.pos_y),
        .o_pos_z     (o_out.pos_z)
    );

endmodule

>>> rtl/kct_datapath.sv
module kct_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [41:0]        i_cfg_data,
    input  logic               i_in_fire,
    input  logic signed [31:0] i_meas_x,
    input  logic signed [31:0] i_meas_y,
    input  logic signed [31:0] i_meas_z,
    input  kct_pkg::t_cmd      i_cmd,
    output kct_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_A,
        PH_B,
        PH_EX,
        PH_MUL,
        PH_MFIN,
        PH_DIV,
        PH_DFIN
    } t_ph;

    // configuration
    logic [32:0] r_tick_period;
    logic [40:0] r_q_pos;
    logic [41:0] r_q_cross;
    logic [40:0] r_q_vel;
    logic [40:0] r_r_xy;
    logic [40:0] r_r_z;

    // filter state and scratch
    logic signed [47:0] r_est  [6];
    logic signed [47:0] r_cov  [9];
    logic signed [47:0] r_pred [6];
    logic signed [47:0] r_tmp  [kct_pkg::NTMP];
    logic signed [31:0] r_meas [3];
    logic [14:0]        r_cnt;
    logic [14:0]        r_last;

    // sequencing
    kct_pkg::t_cmd      r_cmd;
    t_ph                r_ph;
    logic               r_busy;
    logic signed [47:0] r_a;
    logic signed [47:0] r_b;

    // multiplier
    logic [47:0] r_ma;
    logic [47:0] r_mb;
    logic        r_neg;
    logic [2:0]  r_step;
    logic [47:0] r_lo;
    logic [48:0] r_mid;
    logic [47:0] r_hi;
    logic [63:0] r_res;

    // divider
    logic [79:0] r_sh;
    logic [47:0] r_rem;
    logic [47:0] r_q;
    logic        r_over;
    logic [6:0]  r_dcnt;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_pos [3];

    function automatic logic signed [47:0] sat49(input logic signed [48:0] v);
        if (v > 49'sh0_7FFF_FFFF_FFFF) return kct_pkg::QMAX;
        if (v < -49'sh0_8000_0000_0000) return kct_pkg::QMIN;
        return v[47:0];
    endfunction

    function automatic logic [47:0] mag(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    // round to q16.16, ties upward, clamp at the top
    function automatic logic signed [31:0] to_port(input logic signed [47:0] v);
        logic signed [48:0] t;
        logic signed [32:0] s;
        t = 49'(v) + 49'sh8000;
        s = 33'(t >>> 16);
        if (s > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        return s[31:0];
    endfunction

    // element addresses for the current axis
    logic [2:0] ep_idx, ev_idx;
    logic [3:0] c0_idx, c1_idx, c2_idx;
    assign ep_idx = {r_cmd.axis, 1'b0};
    assign ev_idx = {r_cmd.axis, 1'b1};
    assign c0_idx = {1'b0, r_cmd.axis, 1'b0} + {2'b00, r_cmd.axis};
    assign c1_idx = c0_idx + 4'd1;
    assign c2_idx = c0_idx + 4'd2;

    // single operand read port
    kct_pkg::t_sel      rd_sel;
    logic signed [47:0] rd_val;
    always_comb begin
        rd_sel = (r_ph == PH_A) ? r_cmd.uop.a : r_cmd.uop.b;
        rd_val = '0;
        if (rd_sel[4]) begin
            rd_val = r_tmp[rd_sel[3:0]];
        end else begin
            case (rd_sel)
                kct_pkg::S_EPOS:  rd_val = r_est[ep_idx];
                kct_pkg::S_EVEL:  rd_val = r_est[ev_idx];
                kct_pkg::S_P00:   rd_val = r_cov[c0_idx];
                kct_pkg::S_P01:   rd_val = r_cov[c1_idx];
                kct_pkg::S_P11:   rd_val = r_cov[c2_idx];
                kct_pkg::S_PRPOS: rd_val = r_pred[ep_idx];
                kct_pkg::S_PRVEL: rd_val = r_pred[ev_idx];
                kct_pkg::S_Z:     rd_val = {r_meas[r_cmd.axis], 16'h0000};
                kct_pkg::S_R:     rd_val = (r_cmd.axis == 2'd2) ? {7'b0, r_r_z}
                                                                : {7'b0, r_r_xy};
                kct_pkg::S_QP:    rd_val = {7'b0, r_q_pos};
                kct_pkg::S_QC:    rd_val = {{6{r_q_cross[41]}}, r_q_cross};
                kct_pkg::S_QV:    rd_val = {7'b0, r_q_vel};
                kct_pkg::S_TP:    rd_val = {15'b0, r_tick_period};
                default:          rd_val = '0;
            endcase
        end
    end

    // shared 24x24 partial product
    logic [23:0] mx, my;
    logic [47:0] pp;
    logic [63:0] mt;
    logic [63:0] msum;
    logic signed [47:0] mul_q;
    always_comb begin
        mx = r_step[0] ? r_ma[47:24] : r_ma[23:0];
        my = r_step[1] ? r_mb[47:24] : r_mb[23:0];
        if (r_step == 3'd3) begin
            mx = r_ma[47:24];
            my = r_mb[47:24];
        end
        pp = 48'(mx) * 48'(my);
        mt = 64'(r_lo) + (64'(r_mid[23:0]) << 24) + 64'h8000_0000;
        msum = (mt >> 32) + (64'(r_mid[48:24]) << 16) + (64'(r_hi) << 16);
        if (r_neg) begin
            mul_q = (r_res > 64'h8000_0000_0000) ? kct_pkg::QMIN : 48'(-r_res);
        end else begin
            mul_q = (r_res > 64'h7FFF_FFFF_FFFF) ? kct_pkg::QMAX : r_res[47:0];
        end
    end

    // divider step and result
    logic [47:0]        rem_n;
    logic               ge;
    logic signed [47:0] div_q;
    always_comb begin
        rem_n = {r_rem[46:0], r_sh[79]};
        ge    = rem_n >= r_b[47:0];
        if (r_a[47]) begin
            div_q = (r_over || r_q > 48'h8000_0000_0000) ? kct_pkg::QMIN : 48'(-r_q);
        end else begin
            div_q = (r_over || r_q[47]) ? kct_pkg::QMAX : r_q;
        end
    end

    // tick counter update and elapsed time
    logic [15:0]        cnt_inc, cnt_new;
    logic               wrap;
    logic [14:0]        n_ticks;
    logic [47:0]        dt_prod;
    logic signed [47:0] dt_val;
    always_comb begin
        cnt_inc = {1'b0, r_cnt} + 16'd1;
        wrap    = cnt_inc > {1'b0, kct_pkg::TICK_WRAP};
        cnt_new = cnt_inc;
        if (wrap) begin
            cnt_new = (cnt_inc >= {1'b0, r_last}) ? cnt_inc - {1'b0, r_last} : 16'd0;
        end
        if (cnt_new > {1'b0, kct_pkg::CNT_MAX}) cnt_new = {1'b0, kct_pkg::CNT_MAX};
        n_ticks = r_cnt - r_last;
        dt_prod = 48'(r_tick_period) * 48'(n_ticks);
        dt_val  = dt_prod[47] ? kct_pkg::QMAX : dt_prod;
    end

    // write-back port
    logic               w_en;
    logic signed [47:0] w_data;
    always_comb begin
        w_en   = 1'b0;
        w_data = '0;
        case (r_ph)
            PH_EX: begin
                case (r_cmd.uop.op)
                    kct_pkg::OP_MOV: begin
                        w_en   = 1'b1;
                        w_data = r_a;
                    end
                    kct_pkg::OP_ADD: begin
                        w_en   = 1'b1;
                        w_data = sat49(49'(r_a) + 49'(r_b));
                    end
                    kct_pkg::OP_SUB: begin
                        w_en   = 1'b1;
                        w_data = sat49(49'(r_a) - 49'(r_b));
                    end
                    kct_pkg::OP_DT: begin
                        w_en   = 1'b1;
                        w_data = dt_val;
                    end
                    kct_pkg::OP_DIV: begin
                        // innovation variance not positive gives zero gain
                        w_en   = (r_b <= 48'sd0);
                        w_data = '0;
                    end
                    default: w_en = 1'b0;
                endcase
            end
            PH_MFIN: begin
                w_en   = 1'b1;
                w_data = mul_q;
            end
            PH_DFIN: begin
                w_en   = 1'b1;
                w_data = div_q;
            end
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= kct_pkg::RST_TICK_PERIOD;
            r_q_pos       <= kct_pkg::RST_Q_POS;
            r_q_cross     <= kct_pkg::RST_Q_CROSS;
            r_q_vel       <= kct_pkg::RST_Q_VEL;
            r_r_xy        <= kct_pkg::RST_R_XY;
            r_r_z         <= kct_pkg::RST_R_Z;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kct_pkg::CFG_TICK_PERIOD: r_tick_period <= i_cfg_data[32:0];
                kct_pkg::CFG_Q_POS:       r_q_pos       <= i_cfg_data[40:0];
                kct_pkg::CFG_Q_CROSS:     r_q_cross     <= i_cfg_data;
                kct_pkg::CFG_Q_VEL:       r_q_vel       <= i_cfg_data[40:0];
                kct_pkg::CFG_R_XY:        r_r_xy        <= i_cfg_data[40:0];
                kct_pkg::CFG_R_Z:         r_r_z         <= i_cfg_data[40:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_est[2*i]    <= kct_pkg::QONE;
                r_est[2*i+1]  <= '0;
                r_pred[2*i]   <= kct_pkg::QONE;
                r_pred[2*i+1] <= '0;
                r_cov[3*i]    <= kct_pkg::QONE;
                r_cov[3*i+1]  <= '0;
                r_cov[3*i+2]  <= kct_pkg::QONE;
            end
            r_cnt       <= '0;
            r_last      <= '0;
            r_cmd       <= '0;
            r_ph        <= PH_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_fire) begin
                r_meas[0] <= i_meas_x;
                r_meas[1] <= i_meas_y;
                r_meas[2] <= i_meas_z;
            end
            if (i_out_ready) r_out_valid <= 1'b0;

            if (i_cmd.start) begin
                r_cmd  <= i_cmd;
                r_busy <= 1'b1;
                r_ph   <= PH_A;
            end

            case (r_ph)
                PH_A: begin
                    r_a  <= rd_val;
                    r_ph <= PH_B;
                end
                PH_B: begin
                    r_b  <= rd_val;
                    r_ph <= PH_EX;
                end
                PH_EX: begin
                    r_busy <= 1'b0;
                    r_ph   <= PH_IDLE;
                    case (r_cmd.uop.op)
                        kct_pkg::OP_MUL: begin
                            r_ma   <= mag(r_a);
                            r_mb   <= mag(r_b);
                            r_neg  <= r_a[47] ^ r_b[47];
                            r_step <= '0;
                            r_busy <= 1'b1;
                            r_ph   <= PH_MUL;
                        end
                        kct_pkg::OP_DIV: begin
                            if (r_b > 48'sd0) begin
                                r_sh   <= {mag(r_a), 32'h0};
                                r_rem  <= '0;
                                r_q    <= '0;
                                r_over <= 1'b0;
                                r_dcnt <= 7'd79;
                                r_busy <= 1'b1;
                                r_ph   <= PH_DIV;
                            end
                        end
                        kct_pkg::OP_TICK: begin
                            r_cnt <= cnt_new[14:0];
                            if (wrap) r_last <= '0;
                        end
                        kct_pkg::OP_DT: r_last <= r_cnt;
                        kct_pkg::OP_OUT: begin
                            r_pos[0]    <= to_port(r_pred[0]);
                            r_pos[1]    <= to_port(r_pred[2]);
                            r_pos[2]    <= to_port(r_pred[4]);
                            r_out_valid <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                PH_MUL: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: r_lo  <= pp;
                        3'd1: r_mid <= {1'b0, pp};
                        3'd2: r_mid <= r_mid + {1'b0, pp};
                        3'd3: r_hi  <= pp;
                        default: begin
                            r_res <= msum;
                            r_ph  <= PH_MFIN;
                        end
                    endcase
                end
                PH_DIV: begin
                    r_rem  <= ge ? rem_n - r_b[47:0] : rem_n;
                    r_over <= r_over | r_q[47];
                    r_q    <= {r_q[46:0], ge};
                    r_sh   <= {r_sh[78:0], 1'b0};
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_dcnt == 7'd0) r_ph <= PH_DFIN;
                end
                PH_MFIN, PH_DFIN: begin
                    r_busy <= 1'b0;
                    r_ph   <= PH_IDLE;
                end
                default: ;
            endcase

            if (w_en) begin
                if (r_cmd.uop.dst[4]) begin
                    r_tmp[r_cmd.uop.dst[3:0]] <= w_data;
                end else begin
                    case (r_cmd.uop.dst)
                        kct_pkg::S_EPOS:  r_est[ep_idx]  <= w_data;
                        kct_pkg::S_EVEL:  r_est[ev_idx]  <= w_data;
                        kct_pkg::S_P00:   r_cov[c0_idx]  <= w_data;
                        kct_pkg::S_P01:   r_cov[c1_idx]  <= w_data;
                        kct_pkg::S_P11:   r_cov[c2_idx]  <= w_data;
                        kct_pkg::S_PRPOS: r_pred[ep_idx] <= w_data;
                        kct_pkg::S_PRVEL: r_pred[ev_idx] <= w_data;
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.out_free = !r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_pos[0];
    assign o_pos_y         = r_pos[1];
    assign o_pos_z         = r_pos[2];

endmodule

>>> rtl/kct_ctrl.sv
module kct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_opcode,
    output logic           o_in_ready,
    output kct_pkg::t_cmd  o_cmd,
    input  kct_pkg::t_stat i_stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_HOLD,
        ST_WAIT
    } t_state;

    t_state        r_state;
    logic [4:0]    r_pc;
    logic [1:0]    r_axis;
    logic          r_fresh;
    kct_pkg::t_cmd r_cmd;

    kct_pkg::t_uop cur;
    logic [4:0]    n_pc;
    logic [1:0]    n_axis;
    logic          n_done;
    logic          last_axis;

    assign cur       = kct_pkg::uop_rom(r_pc);
    assign last_axis = (r_axis == 2'd2);

    // sequencing of the microprogram
    always_comb begin
        n_pc   = r_pc + 5'd1;
        n_axis = r_axis;
        n_done = 1'b0;
        case (r_pc)
            kct_pkg::PC_TICK: begin
                n_pc   = r_fresh ? kct_pkg::PC_COPY : kct_pkg::PC_DR;
                n_axis = 2'd0;
            end
            kct_pkg::PC_COPY_END: begin
                n_pc   = last_axis ? kct_pkg::PC_OUT : kct_pkg::PC_COPY;
                n_axis = r_axis + 2'd1;
            end
            kct_pkg::PC_DR_END: begin
                n_pc   = last_axis ? kct_pkg::PC_OUT : kct_pkg::PC_DR;
                n_axis = r_axis + 2'd1;
            end
            kct_pkg::PC_OUT: n_done = 1'b1;
            kct_pkg::PC_DT: begin
                n_pc   = kct_pkg::PC_OBS;
                n_axis = 2'd0;
            end
            kct_pkg::PC_OBS_END: begin
                n_pc   = kct_pkg::PC_OBS;
                n_axis = r_axis + 2'd1;
                n_done = last_axis;
            end
            default: n_pc = r_pc + 5'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_axis  <= '0;
            r_fresh <= 1'b0;
            r_cmd   <= '0;
        end else begin
            r_cmd.start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_pc    <= i_in_opcode ? kct_pkg::PC_DT : kct_pkg::PC_TICK;
                        r_axis  <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    // the result request waits for a free output register
                    if (cur.op != kct_pkg::OP_OUT || i_stat.out_free) begin
                        r_cmd   <= '{1'b1, cur, r_axis};
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (!i_stat.busy) begin
                        r_pc   <= n_pc;
                        r_axis <= n_axis;
                        if (n_done) begin
                            r_fresh <= (r_pc == kct_pkg::PC_OBS_END);
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = r_cmd;

endmodule

>>> sim/tb_top.sv
module tb_top;
    import kct_pkg::*;

    // fixed-point limits of the internal q16.32 word, held in 64-bit integers
    localparam longint W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint W_MIN = -64'sh0000_8000_0000_0000;
    localparam longint W_ONE = 64'sh0000_0001_0000_0000;
    localparam int     STALL_LIMIT = 25000;
    // an observation returns nothing; OBS_SETTLE is the wait for it to finish
    localparam int     OBS_SETTLE = 1500;

    typedef struct {
        bit          obs;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
    } track_req_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } track_pos_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [41:0] cfg_data;

    kct_in_if  in_bus ();
    kct_out_if out_bus ();

    kalman_cv_tracker_3d u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_bus),
        .o_out     (out_bus),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // tracker model state
    longint          est[6];
    longint          cov[9];
    longint          pred[6];
    bit              fresh;
    int unsigned     tick_cnt;
    int unsigned     last_obs;
    longint unsigned m_tick_period, m_q_pos, m_q_cross, m_q_vel, m_r_xy, m_r_z;

    track_req_t pending_reqs[$];
    track_pos_t expected_pos[$];
    track_req_t cur_req;
    bit         req_taken;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         errors;
    int         quiet_cycles;
    // synthetic target used to build well-formed observation sequences
    int         trk_p[3];
    int         trk_v[3];

    function automatic longint wsat(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    function automatic longint wadd(longint a, longint b);
        return wsat(a + b);
    endfunction

    function automatic longint wsub(longint a, longint b);
        return wsat(a - b);
    endfunction

    // a*b/2^32, rounded on the magnitude (ties away from zero), saturated
    function automatic longint wmul(longint a, longint b);
        logic [95:0] ma, mb, p;
        bit          neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 96'(-a) : 96'(a);
        mb  = (b < 0) ? 96'(-b) : 96'(b);
        p   = (ma * mb + 96'h8000_0000) >> 32;
        if (neg) return (p > 96'h8000_0000_0000) ? W_MIN : -longint'(p[63:0]);
        return (p > 96'(W_MAX)) ? W_MAX : longint'(p[63:0]);
    endfunction

    // num*2^32/den, truncated toward zero, saturated; den positive
    function automatic longint wdiv(longint num, longint den);
        logic [95:0] n, q;
        n = ((num < 0) ? 96'(-num) : 96'(num)) << 32;
        q = n / 96'(den);
        if (num < 0) return (q > 96'h8000_0000_0000) ? W_MIN : -longint'(q[63:0]);
        return (q > 96'(W_MAX)) ? W_MAX : longint'(q[63:0]);
    endfunction

    // q16.32 to q16.16, round half up, saturated
    function automatic logic [31:0] to_q16(longint v);
        logic [63:0] u;
        u = 64'(v + 64'sh0000_8000_0000_0000);
        u = (u + 64'h8000) >> 16;
        if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
        return u[31:0] - 32'h8000_0000;
    endfunction

    task automatic filter_axis(input int ax, input longint dt, input longint z,
                               input longint r);
        longint qc, x0, x1, a, p00, p01, p11, s, k0, k1, innov;
        qc  = longint'({{22{m_q_cross[41]}}, m_q_cross[41:0]});
        x0  = wadd(est[2*ax], wmul(dt, est[2*ax+1]));
        x1  = est[2*ax+1];
        a   = wadd(cov[3*ax+1], wmul(dt, cov[3*ax+2]));
        p00 = wadd(wadd(wadd(cov[3*ax], wmul(dt, cov[3*ax+1])), wmul(dt, a)),
                   longint'(m_q_pos));
        p01 = wadd(a, qc);
        p11 = wadd(cov[3*ax+2], longint'(m_q_vel));
        s   = wadd(p00, r);
        k0  = 0;
        k1  = 0;
        // innovation variance not positive: gains stay zero
        if (s > 0) begin
            k0 = wdiv(p00, s);
            k1 = wdiv(p01, s);
        end
        innov        = wsub(z, x0);
        est[2*ax]    = wadd(x0, wmul(k0, innov));
        est[2*ax+1]  = wadd(x1, wmul(k1, innov));
        cov[3*ax]    = wsub(p00, wmul(k0, p00));
        cov[3*ax+1]  = wsub(p01, wmul(k0, p01));
        cov[3*ax+2]  = wsub(p11, wmul(k1, p01));
    endtask

    task automatic track_step(input track_req_t rq);
        int unsigned c, n;
        longint      dt;
        track_pos_t  e;
        logic [31:0] m[3];
        if (!rq.obs) begin
            c = tick_cnt + 1;
            // counter wrap rebases the count on the last observation
            if (c > TICK_WRAP) begin
                c = (c >= last_obs) ? c - last_obs : 0;
                last_obs = 0;
            end
            if (c > CNT_MAX) c = CNT_MAX;
            tick_cnt = c;
            if (fresh) begin
                for (int i = 0; i < 6; i++) pred[i] = est[i];
                fresh = 0;
            end else begin
                for (int i = 0; i < 3; i++)
                    pred[2*i] = wadd(pred[2*i], wmul(longint'(m_tick_period), pred[2*i+1]));
            end
            e.x = to_q16(pred[0]);
            e.y = to_q16(pred[2]);
            e.z = to_q16(pred[4]);
            expected_pos.push_back(e);
        end else begin
            n        = (tick_cnt - last_obs) & 32'h7FFF;
            dt       = wsat(longint'(m_tick_period * n));
            last_obs = tick_cnt;
            m[0] = rq.mx;
            m[1] = rq.my;
            m[2] = rq.mz;
            for (int i = 0; i < 3; i++)
                filter_axis(i, dt, longint'(signed'(m[i])) * 65536,
                            longint'((i == 2) ? m_r_z : m_r_xy));
            fresh = 1;
        end
    endtask

    task automatic track_reset();
        m_tick_period = RST_TICK_PERIOD;
        m_q_pos       = RST_Q_POS;
        m_q_cross     = RST_Q_CROSS;
        m_q_vel       = RST_Q_VEL;
        m_r_xy        = RST_R_XY;
        m_r_z         = RST_R_Z;
        for (int i = 0; i < 3; i++) begin
            est[2*i]   = W_ONE;
            est[2*i+1] = 0;
            cov[3*i]   = W_ONE;
            cov[3*i+1] = 0;
            cov[3*i+2] = W_ONE;
        end
        for (int i = 0; i < 6; i++) pred[i] = est[i];
        fresh    = 0;
        tick_cnt = 0;
        last_obs = 0;
    endtask

    // clock, 10 time units
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor: requests and results sampled at the rising edge
    always @(posedge i_clk) begin
        track_pos_t e;
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (in_bus.valid && in_bus.ready) begin
                track_step(cur_req);
                req_taken    = 1;
                quiet_cycles = 0;
            end
            if (out_bus.valid && out_bus.ready) begin
                quiet_cycles = 0;
                if (expected_pos.size() == 0) begin
                    $display("%0t unexpected result x=%h y=%h z=%h", $time,
                             out_bus.pos_x, out_bus.pos_y, out_bus.pos_z);
                    errors = errors + 1;
                end else begin
                    e = expected_pos.pop_front();
                    if (out_bus.pos_x !== e.x) begin
                        $display("%0t pos_x expected %h actual %h", $time, e.x, out_bus.pos_x);
                        errors = errors + 1;
                    end
                    if (out_bus.pos_y !== e.y) begin
                        $display("%0t pos_y expected %h actual %h", $time, e.y, out_bus.pos_y);
                        errors = errors + 1;
                    end
                    if (out_bus.pos_z !== e.z) begin
                        $display("%0t pos_z expected %h actual %h", $time, e.z, out_bus.pos_z);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    // driver: inputs change at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid  = 1'b0;
            out_bus.ready = 1'b0;
        end else begin
            out_bus.ready = ($urandom_range(99) >= snk_idle_pct);
            if (!in_bus.valid || req_taken) begin
                req_taken = 0;
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_req       = pending_reqs.pop_front();
                    in_bus.opcode = cur_req.obs;
                    in_bus.meas_x = cur_req.mx;
                    in_bus.meas_y = cur_req.my;
                    in_bus.meas_z = cur_req.mz;
                    in_bus.valid  = 1'b1;
                end else begin
                    in_bus.valid = 1'b0;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] edge_val();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic push_req(input bit obs, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        track_req_t rq;
        rq.obs = obs;
        rq.mx  = x;
        rq.my  = y;
        rq.mz  = z;
        pending_reqs.push_back(rq);
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++) push_req(0, $urandom, $urandom, $urandom);
    endtask

    // mostly a moving target observed with small noise, some wild values
    task automatic push_random(input int n);
        logic [31:0] m[3];
        int          kind;
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < 3; a++) trk_p[a] = trk_p[a] + trk_v[a];
            if ($urandom_range(99) < 30) begin
                kind = $urandom_range(99);
                for (int a = 0; a < 3; a++) begin
                    if (kind < 65)
                        m[a] = trk_p[a] + $signed($urandom_range(8192)) - 4096;
                    else if (kind < 85)
                        m[a] = $urandom;
                    else
                        m[a] = edge_val();
                end
                push_req(1, m[0], m[1], m[2]);
            end else begin
                push_ticks(1);
            end
            if ($urandom_range(99) < 3)
                for (int a = 0; a < 3; a++) begin
                    trk_p[a] = $signed($urandom_range(2000000)) - 1000000;
                    trk_v[a] = $signed($urandom_range(20000)) - 10000;
                end
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_bus.valid || expected_pos.size() != 0)
            @(posedge i_clk);
        repeat (OBS_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [41:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        case (idx)
            CFG_TICK_PERIOD: m_tick_period = val[32:0];
            CFG_Q_POS:       m_q_pos       = val[40:0];
            CFG_Q_CROSS:     m_q_cross     = val[41:0];
            CFG_Q_VEL:       m_q_vel       = val[40:0];
            CFG_R_XY:        m_r_xy        = val[40:0];
            CFG_R_Z:         m_r_z         = val[40:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic cfg_all(input logic [41:0] tp, input logic [41:0] qp, input logic [41:0] qc,
                           input logic [41:0] qv, input logic [41:0] rxy, input logic [41:0] rz);
        cfg_write(CFG_TICK_PERIOD, tp);
        cfg_write(CFG_Q_POS, qp);
        cfg_write(CFG_Q_CROSS, qc);
        cfg_write(CFG_Q_VEL, qv);
        cfg_write(CFG_R_XY, rxy);
        cfg_write(CFG_R_Z, rz);
    endtask

    initial begin
        in_bus.valid  = 1'b0;
        in_bus.opcode = 1'b0;
        in_bus.meas_x = '0;
        in_bus.meas_y = '0;
        in_bus.meas_z = '0;
        out_bus.ready = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        i_rst_n       = 1'b0;
        req_taken     = 0;
        errors        = 0;
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        for (int a = 0; a < 3; a++) begin
            trk_p[a] = 32'h0001_0000;
            trk_v[a] = 32'h0000_0800;
        end
        track_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults, no idling: directed requests first
        push_ticks(2);                                      // dead-reckon from reset
        push_req(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_req(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // zero elapsed ticks
        push_ticks(3);                                      // fresh copy then dead-reckon
        push_req(1, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_0001);
        push_ticks(1);
        push_req(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_ticks(2);
        push_req(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_ticks(2);
        push_req(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // fields ignored on a tick
        push_random(250);
        wait_idle();

        // upper extremes, sender idle
        cfg_all(42'h1_0000_0000, 42'h100_0000_0000, 42'h100_0000_0000,
                42'h100_0000_0000, 42'h100_0000_0000, 42'h100_0000_0000);
        cfg_write(3'd6, $urandom);                          // unknown index, ignored
        src_idle_pct = 47;
        push_random(200);
        wait_idle();

        // negative cross term, zero noise: innovation variance goes non-positive
        cfg_all(42'h1_0000_0000, 42'h0, 42'h300_0000_0000, 42'h0, 42'h0, 42'h0);
        cfg_write(3'd7, $urandom);
        src_idle_pct = 0;
        snk_idle_pct = 47;
        push_ticks(3);
        push_req(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_ticks(5);
        push_req(1, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000);
        push_ticks(5);
        push_req(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_random(200);
        wait_idle();

        // all-zero settings, both sides idle
        cfg_all(42'h0, 42'h0, 42'h0, 42'h0, 42'h0, 42'h0);
        src_idle_pct = 10;
        snk_idle_pct = 10;
        push_random(150);
        wait_idle();

        // random settings over several phases
        for (int ph = 0; ph < 4; ph++) begin
            cfg_all({$urandom_range(1), $urandom},
                    {$urandom_range(511), $urandom} & 42'h1FF_FFFF_FFFF,
                    {$urandom_range(1023), $urandom} & 42'h3FF_FFFF_FFFF,
                    {$urandom_range(511), $urandom} & 42'h1FF_FFFF_FFFF,
                    {$urandom_range(511), $urandom} & 42'h1FF_FFFF_FFFF,
                    {$urandom_range(511), $urandom} & 42'h1FF_FFFF_FFFF);
            src_idle_pct = (ph == 0) ? 0 : (ph == 1) ? 47 : 10;
            snk_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 0 : 10;
            push_random(90);
            wait_idle();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
